// File: sv/grlb_pkg.sv
// Shared types and constants for the greedy round load balancer.
package grlb_pkg;

  localparam int WORKERS       = 4;
  localparam int WEIGHT_BITS   = 12;
  localparam int IDX_BITS      = 2;
  localparam int LOAD_BITS_DEF = 16;

  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef weight_t [WORKERS-1:0]  weight_vec_t;
  typedef idx_t [WORKERS-1:0]     rank_vec_t;

  typedef struct packed {
    weight_t job_weight_0;
    weight_t job_weight_1;
    weight_t job_weight_2;
    weight_t job_weight_3;
    logic    new_period;
  } job_t;

  typedef struct packed {
    weight_t assigned_0;
    weight_t assigned_1;
    weight_t assigned_2;
    weight_t assigned_3;
    idx_t    round_best;
    idx_t    period_leader;
  } result_t;

endpackage

// File: sv/grlb_sort.sv
// Odd-even transposition network that sorts one round of weights, largest first.
module grlb_sort
  import grlb_pkg::*;
(
  input  weight_vec_t weights,
  output weight_vec_t sorted
);

  // Run one compare-exchange layer per worker, alternating even and odd pairs
  always_comb begin
    weight_vec_t stage;
    weight_t     tmp;
    stage = weights;
    tmp   = '0;
    for (int r = 0; r < WORKERS; r++) begin
      for (int k = 0; k < WORKERS - 1; k++) begin
        if (((k + r) & 1) == 0) begin
          if (stage[k] < stage[k+1]) begin
            tmp        = stage[k];
            stage[k]   = stage[k+1];
            stage[k+1] = tmp;
          end
        end
      end
    end
    sorted = stage;
  end

endmodule

// File: sv/grlb_rank.sv
// Ranks workers by load, ascending, with ties going to the lower index.
module grlb_rank
  import grlb_pkg::*;
#(
  parameter int LOAD_BITS = LOAD_BITS_DEF
)
(
  input  logic [WORKERS-1:0][LOAD_BITS-1:0] loads,
  output rank_vec_t                         ranks
);

  // Count the workers that sit ahead of each worker
  always_comb begin
    idx_t cnt;
    cnt = '0;
    for (int i = 0; i < WORKERS; i++) begin
      cnt = '0;
      for (int j = 0; j < WORKERS; j++) begin
        if ((loads[j] < loads[i]) || ((loads[j] == loads[i]) && (j < i))) begin
          cnt = cnt + idx_t'(1);
        end
      end
      ranks[i] = cnt;
    end
  end

endmodule

// File: sv/greedy_round_load_balancer_unit.sv
// Greedy round load balancer: hands each round of jobs to workers by current load.
//
// One round (four job weights) is accepted per clock cycle while job_stall is
// low. The round is held in the input register while the sort, rank, assign
// and load update run in a single pass into the result register, from which the
// result is presented. The per-worker load registers close a loop through that
// pass, which is what sets the rate of one round per cycle while unstalled. The
// least-loaded worker takes the biggest job; loads saturate at 2**LOAD_BITS-1
// and a round with new_period set starts from all loads cleared. round_best is
// the last worker holding the largest assignment; period_leader is the first
// worker with the strictly greatest load above zero, else worker 0. Stall on the
// result side backs up into the input side without dropping a transaction.
module greedy_round_load_balancer_unit
  import grlb_pkg::*;
#(
  parameter int LOAD_BITS = LOAD_BITS_DEF
)
(
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  output logic    job_stall,
  input  job_t    job_data,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result_data
);

  localparam int SUM_BITS = ((LOAD_BITS > WEIGHT_BITS) ? LOAD_BITS : WEIGHT_BITS) + 1;

  logic                              s1_valid;
  job_t                              s1_data;
  logic [WORKERS-1:0][LOAD_BITS-1:0] worker_load;
  logic [WORKERS-1:0][LOAD_BITS-1:0] cur_load;
  logic [WORKERS-1:0][LOAD_BITS-1:0] worker_load_next;
  weight_vec_t                       weights;
  weight_vec_t                       sorted;
  weight_vec_t                       given;
  rank_vec_t                         ranks;
  idx_t                              best_idx;
  idx_t                              lead_idx;
  result_t                           result_next;
  logic                              out_free;
  logic                              move;

  // Handshake: the result register frees when empty or taken
  assign out_free  = !result_valid || !result_stall;
  assign move      = s1_valid && out_free;
  assign job_stall = s1_valid && !out_free;

  // Hold the accepted round in the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!job_stall) begin
      s1_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!job_stall && job_valid) begin
      s1_data <= job_data;
    end
  end

  // Start from cleared loads when a new period begins
  assign cur_load = s1_data.new_period ? '0 : worker_load;

  assign weights[0] = s1_data.job_weight_0;
  assign weights[1] = s1_data.job_weight_1;
  assign weights[2] = s1_data.job_weight_2;
  assign weights[3] = s1_data.job_weight_3;

  grlb_sort u_sort (
    .weights (weights),
    .sorted  (sorted)
  );

  grlb_rank #(
    .LOAD_BITS (LOAD_BITS)
  ) u_rank (
    .loads (cur_load),
    .ranks (ranks)
  );

  // Give each worker the job matching its rank and add it with saturation
  always_comb begin
    logic [SUM_BITS-1:0] sum;
    sum = '0;
    for (int i = 0; i < WORKERS; i++) begin
      given[i] = sorted[ranks[i]];
      sum      = SUM_BITS'(cur_load[i]) + SUM_BITS'(given[i]);
      if (sum > SUM_BITS'({LOAD_BITS{1'b1}})) begin
        worker_load_next[i] = '1;
      end else begin
        worker_load_next[i] = sum[LOAD_BITS-1:0];
      end
    end
  end

  // Pick the last worker with the largest assignment
  always_comb begin
    weight_t best_val;
    best_val = '0;
    best_idx = '0;
    for (int i = 0; i < WORKERS; i++) begin
      if (given[i] >= best_val) begin
        best_val = given[i];
        best_idx = idx_t'(i);
      end
    end
  end

  // Pick the first worker with the strictly greatest updated load
  always_comb begin
    logic [LOAD_BITS-1:0] lead_val;
    lead_val = '0;
    lead_idx = '0;
    for (int i = 0; i < WORKERS; i++) begin
      if (worker_load_next[i] > lead_val) begin
        lead_val = worker_load_next[i];
        lead_idx = idx_t'(i);
      end
    end
  end

  always_comb begin
    result_next.assigned_0    = given[0];
    result_next.assigned_1    = given[1];
    result_next.assigned_2    = given[2];
    result_next.assigned_3    = given[3];
    result_next.round_best    = best_idx;
    result_next.period_leader = lead_idx;
  end

  // Advance loads and the result register together
  always_ff @(posedge clk) begin
    if (rst) begin
      worker_load  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (move) begin
        worker_load <= worker_load_next;
      end
      if (out_free) begin
        result_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      result_data <= result_next;
    end
  end

  // Checks
  weight_vec_t out_given;
  assign out_given[0] = result_data.assigned_0;
  assign out_given[1] = result_data.assigned_1;
  assign out_given[2] = result_data.assigned_2;
  assign out_given[3] = result_data.assigned_3;

  a_load_hold: assert property (@(posedge clk) disable iff (rst)
    !move |=> $stable(worker_load))
    else $error("worker loads changed without a transaction moving");

  a_best_is_max: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (out_given[result_data.round_best] >= out_given[0]) &&
                     (out_given[result_data.round_best] >= out_given[1]) &&
                     (out_given[result_data.round_best] >= out_given[2]) &&
                     (out_given[result_data.round_best] >= out_given[3]))
    else $error("round_best does not hold the largest assignment");

  a_leader_loaded: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_data.period_leader != '0)
      |-> (worker_load[result_data.period_leader] != '0))
    else $error("period_leader points at an idle worker");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid && !s1_valid)
    else $error("pipeline not empty after reset");

endmodule
